>>> sv/vvfe_pkg.sv
// shared types, codes and helpers of the voxel visible-face emitter
package vvfe_pkg;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_CENTRE = 5'b00100,
		ST_PROBE  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	typedef logic [2:0] dir_t;

	localparam dir_t DIR_PX   = 3'd0;
	localparam dir_t DIR_PY   = 3'd1;
	localparam dir_t DIR_NX   = 3'd2;
	localparam dir_t DIR_NY   = 3'd3;
	localparam dir_t DIR_PZ   = 3'd4;
	localparam dir_t DIR_NZ   = 3'd5;
	localparam dir_t DIR_SELF = 3'd6;

	localparam int   NUM_DIRS = 6;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EMIT  = 1'b1;

	localparam logic [2:0]  TEXTURE_ADDR   = 3'd0;
	localparam logic [7:0]  TEXTURE_RESET  = 8'hFF;
	localparam logic [16:0] VERTS_PER_FACE = 17'd4;

	function automatic dir_t lowest_set(input logic [NUM_DIRS-1:0] m);
		dir_t idx;
		idx = DIR_PX;
		for (int i = NUM_DIRS - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> sv/vvfe_ram.sv
// generic single-write, single-read ram with registered read data
module vvfe_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/vvfe_nbr.sv
// neighbour unit: grid address of one neighbour and whether it lies past the chunk edge
module vvfe_nbr #(
	parameter int CHUNK_SIZE = 16
) (
	input  logic [3:0]                   x,
	input  logic [3:0]                   y,
	input  logic [3:0]                   z,
	input  vvfe_pkg::dir_t               dir,
	output logic [3*$clog2((CHUNK_SIZE < 16) ? CHUNK_SIZE : 16)-1:0] addr,
	output logic                         at_edge
);
	import vvfe_pkg::*;

	localparam int         CMAX  = ((CHUNK_SIZE < 16) ? CHUNK_SIZE : 16) - 1;
	localparam int         AXW   = $clog2(CMAX + 1);
	localparam logic [3:0] C_MAX = 4'(CMAX);

	logic [3:0] nx;
	logic [3:0] ny;
	logic [3:0] nz;

	always_comb begin
		nx      = x;
		ny      = y;
		nz      = z;
		at_edge = 1'b0;
		unique case (dir)
			DIR_PX: begin
				at_edge = (x == C_MAX);
				nx      = x + 4'd1;
			end
			DIR_PY: begin
				at_edge = (y == C_MAX);
				ny      = y + 4'd1;
			end
			DIR_NX: begin
				at_edge = (x == 4'd0);
				nx      = x - 4'd1;
			end
			DIR_NY: begin
				at_edge = (y == 4'd0);
				ny      = y - 4'd1;
			end
			DIR_PZ: begin
				at_edge = (z == C_MAX);
				nz      = z + 4'd1;
			end
			DIR_NZ: begin
				at_edge = (z == 4'd0);
				nz      = z - 4'd1;
			end
			default: begin
				at_edge = 1'b0;
			end
		endcase
		addr = {nz[AXW-1:0], ny[AXW-1:0], nx[AXW-1:0]};
	end

endmodule

>>> sv/voxel_visible_face_emitter.sv
// top level of the voxel visible-face emitter: sequencer, grid ram, output register, apb port
//
//  channel   handshake               payload
//  in        in_valid / in_ready     command, voxel_x, voxel_y, voxel_z, solid
//  out       out_valid / out_ready   face_x/y/z, face_direction, face_texture, vertex_base,
//                                    last_face
//  cfg       psel/penable/pwrite     paddr, pwdata, prdata (texture_index at 0)
//
// a voxel write is taken in idle and the next word is taken straight after
// an emit reads the centre and then the six neighbours through one ram port, then emits
// one visible face per cycle; an air voxel frees the input after the centre read
// a face waits in the output register while out_ready is low and the scan holds
// after reset the grid is cleared one entry a cycle, all 2^(3*ceil(log2(min(S,16))))
// entries (4096 at S = 16), with in_ready low; apb writes are taken throughout
module voxel_visible_face_emitter #(
	parameter int CHUNK_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [3:0]  voxel_x,
	input  logic [3:0]  voxel_y,
	input  logic [3:0]  voxel_z,
	input  logic        solid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  face_x,
	output logic [3:0]  face_y,
	output logic [3:0]  face_z,
	output logic [2:0]  face_direction,
	output logic [7:0]  face_texture,
	output logic [16:0] vertex_base,
	output logic        last_face,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vvfe_pkg::*;

	localparam int         CMAX  = ((CHUNK_SIZE < 16) ? CHUNK_SIZE : 16) - 1;
	localparam int         AXW   = $clog2(CMAX + 1);
	localparam int         AW    = 3 * AXW;
	localparam int         DEPTH = 1 << AW;
	localparam logic [3:0] C_MAX = 4'(CMAX);

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [3:0]            x_q;
	logic [3:0]            y_q;
	logic [3:0]            z_q;
	logic [2:0]            step_q;
	logic [NUM_DIRS-1:0]   mask_q;
	logic                  at_edge_q;
	logic [16:0]           vtx_q;
	logic [7:0]            tex_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  in_chunk;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic                  ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic                  ram_rdata;
	dir_t                  nbr_dir;
	logic                  nbr_edge;
	logic                  open_prev;
	logic [NUM_DIRS-1:0]   mask_next;
	dir_t                  pick;
	logic [NUM_DIRS-1:0]   rem;
	logic                  slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_chunk  = (voxel_x <= C_MAX) && (voxel_y <= C_MAX) && (voxel_z <= C_MAX);
	assign slot_free = !out_valid_q || out_ready;

	assign nbr_dir = (state_q == ST_CENTRE) ? DIR_SELF : step_q;

	vvfe_nbr #(
		.CHUNK_SIZE(CHUNK_SIZE)
	) u_nbr (
		.x      (x_q),
		.y      (y_q),
		.z      (z_q),
		.dir    (nbr_dir),
		.addr   (ram_raddr),
		.at_edge(nbr_edge)
	);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = accept && (command == CMD_WRITE) && in_chunk;
			ram_waddr = {voxel_z[AXW-1:0], voxel_y[AXW-1:0], voxel_x[AXW-1:0]};
			ram_wdata = solid;
		end
	end

	vvfe_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// open bit of the neighbour read in the previous cycle
	assign open_prev = at_edge_q || !ram_rdata;

	always_comb begin
		mask_next = mask_q;
		for (int i = 0; i < NUM_DIRS; i++) begin
			if (step_q == 3'(i + 1)) begin
				mask_next[i] = open_prev;
			end
		end
	end

	assign pick = lowest_set(mask_q);

	always_comb begin
		rem = mask_q;
		for (int i = 0; i < NUM_DIRS; i++) begin
			if (pick == 3'(i)) begin
				rem[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			mask_q      <= '0;
			at_edge_q   <= 1'b0;
			vtx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_chunk && (command == CMD_EMIT)) begin
						state_q <= ST_CENTRE;
					end
				end
				ST_CENTRE: begin
					step_q    <= '0;
					mask_q    <= '0;
					at_edge_q <= 1'b0;
					state_q   <= ST_PROBE;
				end
				ST_PROBE: begin
					at_edge_q <= nbr_edge;
					step_q    <= step_q + 3'd1;
					mask_q    <= mask_next;
					if ((step_q == 3'd0) && !ram_rdata) begin
						state_q <= ST_IDLE;
					end else if (step_q == 3'(NUM_DIRS)) begin
						state_q <= (mask_next == '0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						vtx_q  <= vtx_q + VERTS_PER_FACE;
						mask_q <= rem;
						if (rem == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_EMIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= voxel_x;
			y_q <= voxel_y;
			z_q <= voxel_z;
		end
		if ((state_q == ST_EMIT) && slot_free) begin
			face_x         <= x_q;
			face_y         <= y_q;
			face_z         <= z_q;
			face_direction <= pick;
			face_texture   <= tex_q;
			vertex_base    <= vtx_q;
			last_face      <= (rem == '0);
		end
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_q <= TEXTURE_RESET;
		end else if (psel && penable && pwrite && (paddr == TEXTURE_ADDR)) begin
			tex_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == TEXTURE_ADDR) ? {24'd0, tex_q} : 32'd0;

endmodule

>>> sv/vvfe_chk.sv
// port checker for the voxel visible-face emitter and its bind
module vvfe_chk #(
	parameter int CHUNK_SIZE = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        command,
	input logic [3:0]  voxel_x,
	input logic [3:0]  voxel_y,
	input logic [3:0]  voxel_z,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  face_direction,
	input logic [16:0] vertex_base,
	input logic        last_face
);
	import vvfe_pkg::*;

	logic emit_in_chunk;

	assign emit_in_chunk = (command == CMD_EMIT) &&
		({3'd0, voxel_x} < 7'(CHUNK_SIZE)) &&
		({3'd0, voxel_y} < 7'(CHUNK_SIZE)) &&
		({3'd0, voxel_z} < 7'(CHUNK_SIZE));

	// a held word keeps its vertex base, direction and last-face flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_base) &&
			$stable(face_direction) && $stable(last_face))
		else $error("face word changed while stalled");

	// faces of one voxel keep the input closed until the last one
	a_busy_mid_voxel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_face |-> !in_ready)
		else $error("input open before last face of voxel");

	// vertex base steps by four from one face to the next
	a_vertex_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid ||
			(vertex_base == 17'($past(vertex_base) + VERTS_PER_FACE)))
		else $error("vertex base did not advance by four");

	// an emit inside the chunk occupies the sequencer
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && emit_in_chunk |=> !in_ready)
		else $error("input still open after emit word");

endmodule

bind voxel_visible_face_emitter vvfe_chk #(.CHUNK_SIZE(CHUNK_SIZE)) u_chk (.*);
